// ----- sv/spr_pkg.sv -----
// ----------------------------------------------------------------------------
// spr_pkg: shared types and helpers for the stream pattern replacer
// Window depth, register map codes, the result word and byte lane helpers.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int LEN_W       = 5;
    localparam int IDX_W       = 4;
    localparam int BUDGET_W    = 16;
    localparam int CFG_W       = 64;
    localparam int ADDR_W      = 6;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 16'd99;

    typedef logic [7:0] t_byte;

    typedef enum logic [2:0] {
        REG_PATTERN_LO = 3'd0,
        REG_PATTERN_HI = 3'd1,
        REG_REPL_LO    = 3'd2,
        REG_REPL_HI    = 3'd3,
        REG_PATTERN_LEN = 3'd4,
        REG_REPL_LEN   = 3'd5,
        REG_MAX_REPL   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        t_byte out_byte;
        logic  byte_valid;
        logic  last_of_run;
        logic  stream_done;
    } t_result;

    // byte k of a 16-byte value held as two 64-bit halves
    function automatic t_byte byte_of(input logic [CFG_W-1:0] lo,
                                      input logic [CFG_W-1:0] hi,
                                      input logic [IDX_W-1:0] k);
        logic [2*CFG_W-1:0] w;
        w = {hi, lo};
        return w[{k, 3'b000} +: 8];
    endfunction

    // saturate at the window depth, optionally forcing zero up to one
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                    input logic             at_least_one);
        logic [LEN_W-1:0] r;
        if (v == '0 && at_least_one) begin
            r = LEN_W'(1);
        end else if (v > LEN_W'(MAX_PATTERN)) begin
            r = LEN_W'(MAX_PATTERN);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- sv/spr_cell.sv -----
// ----------------------------------------------------------------------------
// spr_cell: one window cell
// Holds one stream byte, passes it on to the next cell on every shift and
// compares it with the pattern byte expected at its position.
// ----------------------------------------------------------------------------
module spr_cell
    import spr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_shift,
    input  t_byte i_din,
    input  t_byte i_expect,
    output t_byte o_byte,
    output logic  o_eq
);

    t_byte r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_din;
        end
    end

    assign o_byte = r_byte;
    assign o_eq   = (r_byte == i_expect);

endmodule

// ----- sv/spr_out_fifo.sv -----
// ----------------------------------------------------------------------------
// spr_out_fifo: two-entry result queue
// Parts the window logic from the output stream so a new byte can be taken
// while a finished result still waits on the receiver.
// ----------------------------------------------------------------------------
module spr_out_fifo
    import spr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_result i_wdata,
    input  logic    i_rd,
    output logic    o_valid,
    output logic    o_full,
    output t_result o_rdata
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_wr) - 2'(i_rd);
        end
    end

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_rdata = r_mem[r_rd_ptr];

endmodule

// ----- sv/stream_pattern_replace_top.sv -----
// ----------------------------------------------------------------------------
// stream_pattern_replace_top: streaming find and replace on a byte stream
// Replaces up to a budget of pattern matches per stream with a fixed string.
// ----------------------------------------------------------------------------
// Bytes enter on the s_axis channel, tlast marking the final byte of a
// stream. The rewritten stream leaves on m_axis: tdata is the byte, tlast
// closes the results of one input transfer, tuser[0] flags a real byte and
// tuser[1] closes the whole stream. A stream's final input transfer that
// replaces a match with an empty string yields one transfer with tuser[0]
// low. Pattern, replacement, their lengths and the budget are set over the
// APB port, by the user only while the block is idle (the block does not
// enforce this); writing the pattern length empties the window, writing the
// budget reloads the remaining count. The window is a chain of 16 cells; a
// match is checked in the cycle a byte is accepted, and its result is
// registered in the output queue before it shows on m_axis. One byte per
// cycle is sustained while each byte gives at most one result and the queue
// has room; a longer replacement and the flush at a stream's end hold the
// input until their bytes are in the queue. A two-entry output queue holds
// results while the receiver stalls; once full, it backs up s_axis_tready.
// Reset clears window fill, queue and burst counters and loads the register
// reset values, including a budget of 99.
// ----------------------------------------------------------------------------
module stream_pattern_replace_top
    import spr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
    input  logic              s_axis_tlast,   // end_of_stream
    // output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [7:0] out_byte
    output logic              m_axis_tlast,   // last_of_run
    output logic [1:0]        m_axis_tuser    // [0] byte_valid, [1] stream_done
);

    // configuration
    logic [CFG_W-1:0]    r_pat_lo, r_pat_hi, r_rep_lo, r_rep_hi;
    logic [LEN_W-1:0]    r_pat_len, r_rep_len;
    logic [BUDGET_W-1:0] r_max_repl;

    // window and burst state
    logic [LEN_W-1:0]    r_fill;
    logic [BUDGET_W-1:0] r_left;
    logic [LEN_W-1:0]    r_rep_cnt;
    logic [IDX_W-1:0]    r_rep_idx;
    logic [LEN_W-1:0]    r_flush_cnt;
    logic                r_eos;

    logic                w_cfg_wr;
    t_reg_idx            w_reg;
    logic [LEN_W-1:0]    w_plen, w_rlen;
    logic [LEN_W-1:0]    w_plen_m1, w_plen_m2;
    logic [LEN_W-1:0]    w_flush_m1;

    t_byte               w_cell_byte [MAX_PATTERN];
    t_byte               w_expect    [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_eq, w_mask;

    logic                w_pending, w_accept, w_full, w_match, w_do_rep, w_single;
    logic                w_rep_first, w_empty;
    logic [LEN_W-1:0]    w_fill_new;
    logic [IDX_W-1:0]    w_rd_idx;
    t_byte               w_rd_byte, w_single_byte;

    logic                w_wr, w_fifo_full, w_fifo_valid, w_rd;
    t_result             w_wdata, w_rdata;

    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_reg    = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign pready   = 1'b1;

    assign w_plen     = clamp_len(r_pat_len, 1'b1);
    assign w_rlen     = clamp_len(r_rep_len, 1'b0);
    assign w_plen_m1  = w_plen - LEN_W'(1);
    assign w_plen_m2  = w_plen - LEN_W'(2);
    assign w_flush_m1 = r_flush_cnt - LEN_W'(1);

    // cell chain: cell 0 takes the incoming byte, newest byte lowest
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        logic [LEN_W-1:0] w_pos;
        t_byte            w_din;

        // cell j lines up with pattern byte plen-2-j when the window is one short
        assign w_pos       = w_plen_m2 - LEN_W'(j);
        assign w_expect[j] = byte_of(r_pat_lo, r_pat_hi, w_pos[IDX_W-1:0]);
        assign w_mask[j]   = (LEN_W'(j + 1) < w_plen);

        if (j == 0) begin : g_head
            assign w_din = s_axis_tdata;
        end else begin : g_link
            assign w_din = w_cell_byte[j-1];
        end

        spr_cell u_cell (
            .i_clk    (i_clk),
            .i_shift  (w_accept),
            .i_din    (w_din),
            .i_expect (w_expect[j]),
            .o_byte   (w_cell_byte[j]),
            .o_eq     (w_eq[j])
        );
    end

    assign w_pending     = (r_rep_cnt != '0) || (r_flush_cnt != '0);
    assign s_axis_tready = !w_pending && !w_fifo_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_full  = ((r_fill + LEN_W'(1)) == w_plen);
    assign w_match = w_full && (&(w_eq | ~w_mask))
                     && (s_axis_tdata == byte_of(r_pat_lo, r_pat_hi, w_plen_m1[IDX_W-1:0]));
    assign w_do_rep    = w_match && (r_left != '0);
    assign w_single    = w_full && !w_do_rep;
    assign w_rep_first = w_do_rep && (w_rlen != '0);
    assign w_empty     = w_do_rep && (w_rlen == '0) && s_axis_tlast;

    always_comb begin
        if (w_do_rep) begin
            w_fill_new = '0;
        end else if (w_full) begin
            w_fill_new = w_plen_m1;
        end else begin
            w_fill_new = r_fill + LEN_W'(1);
        end
    end

    // single read port on the cells: flush position while bursting, else the oldest
    assign w_rd_idx      = w_pending ? w_flush_m1[IDX_W-1:0] : w_plen_m2[IDX_W-1:0];
    assign w_rd_byte     = w_cell_byte[w_rd_idx];
    assign w_single_byte = (w_plen == LEN_W'(1)) ? s_axis_tdata : w_rd_byte;

    always_comb begin
        w_wr    = 1'b0;
        w_wdata = '0;
        if (w_pending) begin
            w_wr = !w_fifo_full;
            if (r_rep_cnt != '0) begin
                w_wdata.out_byte    = byte_of(r_rep_lo, r_rep_hi, r_rep_idx);
                w_wdata.byte_valid  = 1'b1;
                w_wdata.last_of_run = (r_rep_cnt == LEN_W'(1));
                w_wdata.stream_done = (r_rep_cnt == LEN_W'(1)) && r_eos;
            end else begin
                w_wdata.out_byte    = w_rd_byte;
                w_wdata.byte_valid  = 1'b1;
                w_wdata.last_of_run = (r_flush_cnt == LEN_W'(1));
                w_wdata.stream_done = (r_flush_cnt == LEN_W'(1)) && r_eos;
            end
        end else if (w_accept) begin
            priority if (w_rep_first) begin
                w_wr                = 1'b1;
                w_wdata.out_byte    = byte_of(r_rep_lo, r_rep_hi, '0);
                w_wdata.byte_valid  = 1'b1;
                w_wdata.last_of_run = (w_rlen == LEN_W'(1));
                w_wdata.stream_done = (w_rlen == LEN_W'(1)) && s_axis_tlast;
            end else if (w_single) begin
                w_wr                = 1'b1;
                w_wdata.out_byte    = w_single_byte;
                w_wdata.byte_valid  = 1'b1;
                w_wdata.last_of_run = !s_axis_tlast || (w_plen == LEN_W'(1));
                w_wdata.stream_done = s_axis_tlast && (w_plen == LEN_W'(1));
            end else if (w_empty) begin
                w_wr                = 1'b1;
                w_wdata.out_byte    = '0;
                w_wdata.byte_valid  = 1'b0;
                w_wdata.last_of_run = 1'b1;
                w_wdata.stream_done = 1'b1;
            end else begin
                w_wr = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo    <= '0;
            r_pat_hi    <= '0;
            r_rep_lo    <= '0;
            r_rep_hi    <= '0;
            r_pat_len   <= LEN_W'(1);
            r_rep_len   <= '0;
            r_max_repl  <= BUDGET_RESET;
            r_fill      <= '0;
            r_left      <= BUDGET_RESET;
            r_rep_cnt   <= '0;
            r_rep_idx   <= '0;
            r_flush_cnt <= '0;
            r_eos       <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                unique case (w_reg)
                    REG_PATTERN_LO:  r_pat_lo <= pwdata;
                    REG_PATTERN_HI:  r_pat_hi <= pwdata;
                    REG_REPL_LO:     r_rep_lo <= pwdata;
                    REG_REPL_HI:     r_rep_hi <= pwdata;
                    REG_PATTERN_LEN: begin
                        r_pat_len <= pwdata[LEN_W-1:0];
                        r_fill    <= '0;
                    end
                    REG_REPL_LEN:    r_rep_len <= pwdata[LEN_W-1:0];
                    REG_MAX_REPL: begin
                        r_max_repl <= pwdata[BUDGET_W-1:0];
                        r_left     <= pwdata[BUDGET_W-1:0];
                    end
                    default: ;
                endcase
            end

            if (w_accept) begin
                r_fill      <= s_axis_tlast ? '0 : w_fill_new;
                r_rep_cnt   <= w_rep_first ? (w_rlen - LEN_W'(1)) : '0;
                r_rep_idx   <= IDX_W'(1);
                r_flush_cnt <= s_axis_tlast ? w_fill_new : '0;
                r_eos       <= s_axis_tlast;
                if (s_axis_tlast) begin
                    r_left <= r_max_repl;
                end else if (w_do_rep) begin
                    r_left <= r_left - BUDGET_W'(1);
                end
            end else if (w_wr) begin
                // burst transfer into the queue
                if (r_rep_cnt != '0) begin
                    r_rep_cnt <= r_rep_cnt - LEN_W'(1);
                    r_rep_idx <= r_rep_idx + IDX_W'(1);
                end else begin
                    r_flush_cnt <= w_flush_m1;
                end
            end
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_PATTERN_LO:  prdata = r_pat_lo;
            REG_PATTERN_HI:  prdata = r_pat_hi;
            REG_REPL_LO:     prdata = r_rep_lo;
            REG_REPL_HI:     prdata = r_rep_hi;
            REG_PATTERN_LEN: prdata = CFG_W'(r_pat_len);
            REG_REPL_LEN:    prdata = CFG_W'(r_rep_len);
            REG_MAX_REPL:    prdata = CFG_W'(r_max_repl);
            default:         prdata = '0;
        endcase
    end

    assign w_rd = w_fifo_valid && m_axis_tready;

    spr_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_wdata (w_wdata),
        .i_rd    (w_rd),
        .o_valid (w_fifo_valid),
        .o_full  (w_fifo_full),
        .o_rdata (w_rdata)
    );

    assign m_axis_tvalid = w_fifo_valid;
    assign m_axis_tdata  = w_rdata.out_byte;
    assign m_axis_tlast  = w_rdata.last_of_run;
    assign m_axis_tuser  = {w_rdata.stream_done, w_rdata.byte_valid};

endmodule

// ----- bench/stream_pattern_replace_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_pattern_replace_top_tb: self-checking bench for the byte find/replace
// Bytes go in on s_axis and are rewritten by a local model of the replacer
// that also tracks the register writes made over APB. Each m_axis transfer is
// checked in order against the expected bytes. Directed streams cover reset
// values, byte and length extremes, exhausted budget, empty end markers and
// register rewrites. Random streams then run under several settings, with
// random idling on both sides and a long receiver stall.
// ----------------------------------------------------------------------------
module stream_pattern_replace_top_tb;
    import spr_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int LONG_STALL  = 400;
    localparam int IDLE_GUARD  = 8;
    localparam int END_GUARD   = 16;
    localparam int MAX_PRINTS  = 50;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [CFG_W-1:0]  pwdata = '0;
    logic [CFG_W-1:0]  prdata;
    logic              pready;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;   // [7:0] data_byte
    logic              s_axis_tlast = 1'b0; // end_of_stream
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;        // [7:0] out_byte
    logic              m_axis_tlast;        // last_of_run
    logic [1:0]        m_axis_tuser;        // [0] byte_valid, [1] stream_done

    // local copy of the registers and the lookahead window
    logic [63:0] pat_lo = '0;
    logic [63:0] pat_hi = '0;
    logic [63:0] rep_lo = '0;
    logic [63:0] rep_hi = '0;
    logic [4:0]  pat_len_reg = 5'd1;
    logic [4:0]  rep_len_reg = 5'd0;
    logic [15:0] budget_max = BUDGET_RESET;
    logic [15:0] budget_left = BUDGET_RESET;
    t_byte       win [MAX_PATTERN];
    int          win_fill = 0;

    t_result expected_q[$];

    int fail_count = 0;
    int bytes_in = 0;
    int results_checked = 0;
    int streams_sent = 0;
    int settings_used = 1;
    int src_idle_pct = 10;
    int snk_idle_pct = 47;
    int quiet_cycles = 0;
    int stall_left = 0;
    logic stall_toggle = 1'b0;
    logic stall_seen = 1'b0;

    stream_pattern_replace_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // rewrite model
    // ------------------------------------------------------------------
    function automatic t_byte lane(input logic [63:0] lo, input logic [63:0] hi,
                                   input int k);
        if (k < 8) begin
            return lo[8*k +: 8];
        end
        return hi[8*(k-8) +: 8];
    endfunction

    function automatic int eff_pattern_len();
        if (pat_len_reg == 5'd0) begin
            return 1;
        end
        if (pat_len_reg > 5'(MAX_PATTERN)) begin
            return MAX_PATTERN;
        end
        return int'(pat_len_reg);
    endfunction

    function automatic t_result data_result(input t_byte b, input logic valid);
        t_result res;
        res.out_byte    = b;
        res.byte_valid  = valid;
        res.last_of_run = 1'b0;
        res.stream_done = 1'b0;
        return res;
    endfunction

    function automatic void rewrite_byte(input t_byte b, input logic eos);
        t_result burst [MAX_PATTERN];
        int      plen;
        int      rlen;
        int      n;
        logic    hit;
        plen = eff_pattern_len();
        rlen = (rep_len_reg > 5'(MAX_PATTERN)) ? MAX_PATTERN : int'(rep_len_reg);
        n = 0;
        if (win_fill < MAX_PATTERN) begin
            win[win_fill] = b;
            win_fill++;
        end
        if (win_fill >= plen) begin
            hit = 1'b1;
            for (int i = 0; i < plen; i++) begin
                if (win[i] != lane(pat_lo, pat_hi, i)) hit = 1'b0;
            end
            if (hit && budget_left != 16'd0) begin
                budget_left--;
                for (int i = 0; i < rlen; i++) begin
                    burst[n] = data_result(lane(rep_lo, rep_hi, i), 1'b1);
                    n++;
                end
                for (int i = 0; i < MAX_PATTERN - plen; i++) win[i] = win[i+plen];
                win_fill -= plen;
            end else begin
                burst[n] = data_result(win[0], 1'b1);
                n++;
                for (int i = 0; i < MAX_PATTERN - 1; i++) win[i] = win[i+1];
                win_fill--;
            end
        end
        if (eos) begin
            // partial matches never count at the end, the window leaves as is
            for (int i = 0; i < win_fill && n < MAX_PATTERN; i++) begin
                burst[n] = data_result(win[i], 1'b1);
                n++;
            end
            win_fill = 0;
            budget_left = budget_max;
            if (n == 0) begin
                burst[n] = data_result(8'h00, 1'b0);
                n++;
            end
            burst[n-1].stream_done = 1'b1;
        end
        if (n > 0) burst[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++) expected_q.push_back(burst[i]);
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= MAX_PRINTS) begin
            $display("mismatch at result %0d: %s is %0h, expected %0h",
                     results_checked, what, got, want);
        end
    endtask

    task automatic check_result(input t_byte data, input logic last,
                                input logic [1:0] user);
        t_result want;
        if (expected_q.size() == 0) begin
            report_mismatch("unexpected transfer, out_byte", data, 0);
        end else begin
            want = expected_q.pop_front();
            if (data != want.out_byte)
                report_mismatch("out_byte", data, want.out_byte);
            if (user[0] != want.byte_valid)
                report_mismatch("byte_valid", user[0], want.byte_valid);
            if (last != want.last_of_run)
                report_mismatch("last_of_run", last, want.last_of_run);
            if (user[1] != want.stream_done)
                report_mismatch("stream_done", user[1], want.stream_done);
            results_checked++;
        end
    endtask

    // output checked before the input of the same edge is predicted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready) begin
                rewrite_byte(s_axis_tdata, s_axis_tlast);
                bytes_in++;
            end
        end
    end

    // receiver: random idling, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (stall_toggle != stall_seen) begin
            stall_seen <= stall_toggle;
            stall_left <= LONG_STALL;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_byte(input t_byte b, input logic eos);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // sender pauses until every expected byte is out
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_GUARD) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PATTERN_LO:  pat_lo = val;
            REG_PATTERN_HI:  pat_hi = val;
            REG_REPL_LO:     rep_lo = val;
            REG_REPL_HI:     rep_hi = val;
            REG_PATTERN_LEN: begin
                pat_len_reg = val[4:0];
                win_fill = 0;
            end
            REG_REPL_LEN:    rep_len_reg = val[4:0];
            REG_MAX_REPL: begin
                budget_max  = val[15:0];
                budget_left = val[15:0];
            end
            default: ;
        endcase
        // the bus goes idle between register transfers
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [63:0] p_lo, input logic [63:0] p_hi,
                             input logic [63:0] r_lo, input logic [63:0] r_hi,
                             input logic [4:0] plen, input logic [4:0] rlen,
                             input logic [15:0] budget);
        write_reg(REG_PATTERN_LO, p_lo);
        write_reg(REG_PATTERN_HI, p_hi);
        write_reg(REG_REPL_LO, r_lo);
        write_reg(REG_REPL_HI, r_hi);
        write_reg(REG_PATTERN_LEN, 64'(plen));
        write_reg(REG_REPL_LEN, 64'(rlen));
        write_reg(REG_MAX_REPL, 64'(budget));
        settings_used++;
    endtask

    // mostly whole pattern copies and near misses, some plain noise
    task automatic send_stream(input int want_len, output int sent);
        t_byte stream_q[$];
        int    plen;
        int    r;
        int    cut;
        plen = eff_pattern_len();
        while (stream_q.size() < want_len) begin
            r = $urandom_range(99);
            if (r < 45) begin
                for (int k = 0; k < plen; k++) stream_q.push_back(lane(pat_lo, pat_hi, k));
            end else if (r < 60) begin
                cut = $urandom_range(plen - 1);
                for (int k = 0; k < cut; k++) stream_q.push_back(lane(pat_lo, pat_hi, k));
                stream_q.push_back(lane(pat_lo, pat_hi, cut) ^ t_byte'($urandom_range(1, 255)));
            end else if (r < 85) begin
                stream_q.push_back(lane(pat_lo, pat_hi, $urandom_range(plen - 1)));
            end else begin
                stream_q.push_back(t_byte'($urandom));
            end
        end
        for (int j = 0; j < stream_q.size(); j++)
            send_byte(stream_q[j], j == stream_q.size() - 1);
        sent = stream_q.size();
        streams_sent++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_values();
        // reset pattern is one zero byte with an empty replacement
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        streams_sent += 2;
    endtask

    task automatic test_replace_extremes();
        wait_idle();
        write_all(64'hFFFF_FFFF_FF5A_FF00, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
                  5'd3, 5'd16, 16'd1);
        // second copy passes through, budget used up; it closes the stream
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
        streams_sent++;
    endtask

    task automatic test_length_saturation();
        wait_idle();
        // zero pattern length acts as one, replacement length saturates
        write_reg(REG_PATTERN_LEN, 64'd0);
        write_reg(REG_REPL_LEN, 64'd31);
        write_reg(REG_MAX_REPL, 64'hFFFF);
        settings_used++;
        send_byte(8'h00, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b1);
        streams_sent += 2;
    endtask

    task automatic test_register_rewrite();
        wait_idle();
        write_all(64'h0000_0000_0000_FF00, 64'h0, 64'h0000_0000_0000_00FF, 64'h0,
                  5'd2, 5'd1, 16'd0);
        // no budget: the match leaves byte by byte
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        wait_idle();
        // window holds one byte; the length write drops it, budget reloads
        write_reg(REG_PATTERN_LEN, 64'd2);
        write_reg(REG_MAX_REPL, 64'd1);
        settings_used++;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        streams_sent++;
    endtask

    task automatic test_output_backpressure();
        int sent;
        wait_idle();
        write_all(64'h0000_0000_0000_0033, 64'h0, {$urandom, $urandom}, 64'h0,
                  5'd1, 5'd8, 16'hFFFF);
        stall_toggle <= ~stall_toggle;
        send_stream(60, sent);
        wait_idle();
    endtask

    task automatic test_random_setting(input int n_bytes);
        logic [63:0] p_lo;
        logic [63:0] p_hi;
        t_byte       alpha [4];
        t_byte       b;
        logic [4:0]  plen_val;
        logic [4:0]  rlen_val;
        logic [15:0] budget;
        int          r;
        int          total;
        int          sent;
        for (int k = 0; k < 4; k++) alpha[k] = t_byte'($urandom);
        // few distinct symbols so that overlaps and repeats show up
        for (int k = 0; k < MAX_PATTERN; k++) begin
            b = ($urandom_range(3) == 0) ? t_byte'($urandom) : alpha[$urandom_range(3)];
            if (k < 8) p_lo[8*k +: 8] = b;
            else p_hi[8*(k-8) +: 8] = b;
        end
        r = $urandom_range(99);
        if (r < 60)      plen_val = 5'($urandom_range(1, 3));
        else if (r < 80) plen_val = 5'($urandom_range(4, 8));
        else if (r < 92) plen_val = 5'($urandom_range(9, 16));
        else if (r < 96) plen_val = 5'd0;
        else             plen_val = 5'($urandom_range(17, 31));
        r = $urandom_range(99);
        rlen_val = (r < 90) ? 5'($urandom_range(0, 16)) : 5'($urandom_range(17, 31));
        r = $urandom_range(99);
        if (r < 15)      budget = 16'd0;
        else if (r < 70) budget = 16'($urandom_range(1, 4));
        else if (r < 88) budget = 16'($urandom_range(5, 200));
        else if (r < 94) budget = 16'hFFFF;
        else             budget = 16'($urandom);
        wait_idle();
        write_all(p_lo, p_hi, {$urandom, $urandom}, {$urandom, $urandom},
                  plen_val, rlen_val, budget);
        total = 0;
        while (total < n_bytes) begin
            r = ($urandom_range(9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 20);
            send_stream(r, sent);
            total += sent;
        end
    endtask

    task automatic test_random_phase();
        repeat (3) test_random_setting(48);
    endtask

    initial begin
        for (int k = 0; k < MAX_PATTERN; k++) win[k] = 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_replace_extremes();
        test_length_saturation();
        test_register_rewrite();
        test_random_phase();

        src_idle_pct = 47;
        snk_idle_pct = 10;
        test_random_phase();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_output_backpressure();
        test_random_phase();

        wait_idle();
        repeat (END_GUARD) @(posedge i_clk);

        $display("covered %0d input transfers in %0d streams, %0d results checked",
                 bytes_in, streams_sent, results_checked);
        $display("over %0d register settings, random idling and a long output stall",
                 settings_used);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/spr_pkg.sv
sv/spr_cell.sv
sv/spr_out_fifo.sv
sv/stream_pattern_replace_top.sv
bench/stream_pattern_replace_top_tb.sv
